>>> design/tmc_pkg.sv
// Shared types, geometry constants and character codes for the text mode console.
// Used by every module of the console and by its checker. No dependencies.
package tmc_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int SCROLL_LEN = (ROWS - 1) * COLUMNS;

  // Field widths fixed by the interface.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int LOC_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Cell address width and the address constants used by the sweeps.
  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam logic [CELL_AW-1:0] COLS_A       = CELL_AW'(COLUMNS);
  localparam logic [CELL_AW-1:0] SCROLL_LEN_A = CELL_AW'(SCROLL_LEN);
  localparam logic [CELL_AW-1:0] LAST_CELL_A  = CELL_AW'(CELL_COUNT - 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Command kinds after classification.
  typedef enum logic [2:0] {
    K_PRINT = 3'd0,
    K_BS    = 3'd1,
    K_TAB   = 3'd2,
    K_CR    = 3'd3,
    K_LF    = 3'd4,
    K_NOP   = 3'd5,
    K_CLEAR = 3'd6,
    K_READ  = 3'd7
  } kind_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] character;
    logic [LOC_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_value;
  } out_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  character;
    logic [CELL_AW-1:0] addr;
    logic               in_range;
  } cmd_t;

endpackage

>>> design/tmc_front.sv
// Front end of the text mode console: classifies input transactions into commands
// and holds them in a two-entry command queue. Depends on tmc_pkg.
module tmc_front import tmc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     cmd_empty,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    cls.kind      = K_NOP;
    cls.character = item.character;
    cls.addr      = item.cell_index[CELL_AW-1:0];
    cls.in_range  = (item.cell_index < LOC_W'(CELL_COUNT));
    case (item.operation)
      OP_PUT: begin
        if (item.character inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
          cls.kind = K_PRINT;
        end else begin
          case (item.character)
            CH_BS:   cls.kind = K_BS;
            CH_TAB:  cls.kind = K_TAB;
            CH_CR:   cls.kind = K_CR;
            CH_LF:   cls.kind = K_LF;
            default: cls.kind = K_NOP;
          endcase
        end
      end
      OP_CLEAR: cls.kind = K_CLEAR;
      OP_READ:  cls.kind = K_READ;
      default:  cls.kind = K_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_empty = (count == 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && !cmd_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> design/tmc_back.sv
// Back end of the text mode console: cursor state, screen memory, scroll and clear
// sweeps, and result assembly. Depends on tmc_pkg.
module tmc_back import tmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] attribute_byte,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output out_item_t         res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_FILL   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [COL_W-1:0]   col, col_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [CELL_AW-1:0] cnt, cnt_next;
  logic [CELL_W-1:0]  cell_word, cell_word_next;
  logic               read_ok, read_ok_next;

  logic [CELL_W-1:0]  mem [CELL_COUNT];
  logic [CELL_W-1:0]  rdata;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [CELL_AW-1:0] mem_raddr;
  logic [CELL_W-1:0]  mem_wdata;

  logic [CELL_AW-1:0] cur_addr;
  logic [COL_W:0]     col_w;
  logic [ROW_W:0]     row_w;
  logic               need_scroll;

  assign cur_addr = CELL_AW'(row * COLUMNS) + CELL_AW'(col);

  // Cursor movement for put commands, before the right and bottom edge checks.
  always_comb begin
    col_w = {1'b0, col};
    row_w = {1'b0, row};
    case (cmd.kind)
      K_PRINT: col_w = col_w + 1'b1;
      K_BS: begin
        if (col != '0) begin
          col_w = col_w - 1'b1;
        end
      end
      K_TAB:   col_w = (COL_W+1)'(((int'(col) / TAB_STOP) + 1) * TAB_STOP);
      K_CR:    col_w = '0;
      K_LF: begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      default: col_w = {1'b0, col};
    endcase
    if (col_w >= (COL_W+1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    need_scroll = (row_w == (ROW_W+1)'(ROWS));
  end

  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    cnt_next       = cnt;
    cell_word_next = cell_word;
    read_ok_next   = read_ok;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur_addr;
    mem_wdata      = {attribute_byte, cmd.character};
    mem_raddr      = cmd.addr;
    case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop        = 1'b1;
          cell_word_next = '0;
          case (cmd.kind)
            K_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              cnt_next   = '0;
              state_next = S_FILL;
            end
            K_READ: begin
              read_ok_next = cmd.in_range;
              state_next   = S_READ;
            end
            default: begin
              mem_we   = (cmd.kind == K_PRINT);
              col_next = col_w[COL_W-1:0];
              if (need_scroll) begin
                row_next   = ROW_W'(ROWS - 1);
                cnt_next   = '0;
                state_next = S_SCROLL;
              end else begin
                row_next   = row_w[ROW_W-1:0];
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_READ: begin
        cell_word_next = read_ok ? rdata : '0;
        state_next     = S_DONE;
      end
      S_SCROLL: begin
        // Read one row ahead and write the cell fetched in the previous cycle.
        if (cnt != SCROLL_LEN_A) begin
          mem_raddr = cnt + COLS_A;
        end
        mem_we    = (cnt != '0);
        mem_waddr = cnt - 1'b1;
        mem_wdata = rdata;
        if (cnt == SCROLL_LEN_A) begin
          state_next = S_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = {attribute_byte, CH_BLANK};
        if (cnt == LAST_CELL_A) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res.cursor_location = LOC_W'(row * COLUMNS) + LOC_W'(col);
  assign res.cursor_column   = col;
  assign res.cursor_row      = row;
  assign res.cell_value      = cell_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    cell_word <= cell_word_next;
    read_ok   <= read_ok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

endmodule

>>> design/tmc_outq.sv
// Two-entry result queue of the text mode console, feeding the output channel.
// Depends on tmc_pkg.
module tmc_outq import tmc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_push,
  input  out_item_t res,
  output logic      res_full,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  out_item_t  q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign result   = q[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> design/text_mode_console.sv
// Top level of the text mode console: attribute register, front end, back end
// and result queue. Depends on tmc_pkg, tmc_front, tmc_back and tmc_outq.
//
// Usage: the console looks like a queue on both sides. An input transaction
// (operation, character, cell_index) is taken on a clock edge with push high
// and full low. Every input transaction yields exactly one result transaction
// (cursor location, column, row and cell value), shown while empty is low and
// taken on an edge with pop high. The attribute register is written through
// cfg_we and cfg_data; the user writes it only while the console is idle,
// which the block itself does not enforce. A put that does not scroll goes
// from the idle state straight to the done state; a read passes through an
// extra read state because the screen memory read port is registered.
// Clear sweeps all 2000 cells at one write per cycle; a put that scrolls
// copies 24 rows through the memory's read and write ports and blanks the
// bottom row. The back end works on one command at a time; the command
// queue takes up to two more meanwhile.
// Reset homes the cursor, empties both queues and sets the attribute to 0x0F.
// The screen memory is not cleared by reset; software issues clear first.
// If the receiver stalls, results wait in the two-entry result queue, then
// the back end holds, and full rises once the command queue is full.
module text_mode_console import tmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  in_item_t          item,
  output logic              empty,
  input  logic              pop,
  output out_item_t         result,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data
);

  // Attribute placed in the high byte of written and blank cells.
  logic [ATTR_W-1:0] attribute_byte;

  // Command queue between front and back ends.
  logic cmd_empty;
  logic cmd_pop;
  cmd_t cmd;

  // Result path from the back end into the result queue.
  logic      res_push;
  logic      res_full;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_byte <= ATTR_RESET;
    end else if (cfg_we) begin
      attribute_byte <= cfg_data;
    end
  end

  // Classify incoming transactions and queue them as commands.
  tmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Carry out the commands against the cursor and the screen memory.
  tmc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .attribute_byte (attribute_byte),
    .cmd_empty      (cmd_empty),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res)
  );

  // Decouple the back end from a stalling receiver.
  tmc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

>>> design/tmc_checker.sv
// Port-level checker for the text mode console and the bind that attaches it.
// Depends on tmc_pkg and text_mode_console.
module tmc_checker import tmc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // The cursor shown is always on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.cursor_column < COL_W'(COLUMNS) &&
                result.cursor_row < ROW_W'(ROWS)))
    else $error("cursor off screen");

  // The linear location agrees with the row and column.
  a_location: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.cursor_location ==
                LOC_W'(result.cursor_row * COLUMNS) + LOC_W'(result.cursor_column)))
    else $error("cursor location mismatch");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind text_mode_console tmc_checker u_chk (.*);

>>> verif/tb_text_mode_console.sv
// Self-checking testbench for the text mode console top level.
// Depends on tmc_pkg and text_mode_console; it predicts every result
// transaction and compares it field by field against the console.
module tb_text_mode_console;
  import tmc_pkg::*;

  // Operation code 3 has no meaning; the console must only report the cursor.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int MAX_GAP       = 12;    // longest idle stretch drawn per transaction
  localparam int ITEMS_WANTED  = 1400;  // meaningful random transactions to send
  localparam int PHASES        = 7;     // attribute settings used by the random part
  localparam int HOLD_AFTER    = 300;   // accepted commands before the long stall
  localparam int HOLD_CYCLES   = 250;   // length of the long receiver stall
  localparam int SETTLE_CYCLES = 4;     // quiet cycles before an attribute write
  localparam int DRAIN_CYCLES  = 20;    // quiet cycles at the end of the run
  localparam int MAX_INDEX     = (1 << LOC_W) - 1;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              push     = 1'b0;
  logic              full;
  in_item_t          item     = '0;
  logic              empty;
  logic              pop      = 1'b0;
  out_item_t         result;
  logic              cfg_we   = 1'b0;
  logic [ATTR_W-1:0] cfg_data = '0;

  text_mode_console DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Period of 4 time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Commands waiting to be sent, and the cursor reports the console still owes.
  in_item_t  cmd_backlog [$];
  out_item_t due_reports [$];

  // Handshake outcomes captured at the rising edge and used by the drivers at
  // the following falling edge, so no process reads a value that is changing.
  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;

  bit hold_results = 1'b0;  // receiver refuses every result while set
  bit brisk        = 1'b0;  // no idling on either side while set
  int send_gap     = 0;
  int recv_gap     = 0;

  int    queued_cmds     = 0;
  int    accepted_cmds   = 0;
  int    counted_cmds    = 0;  // commands the console does not simply ignore
  int    checked_results = 0;
  int    mismatches      = 0;
  int    shades_used     = 1;
  int    clear_count     = 0;
  int    scroll_count    = 0;
  int    read_count      = 0;
  longint budget         = 0;  // pessimistic cycle estimate for the queued work
  longint cycles         = 0;

  // Shadow copy of the console: screen contents, cursor and attribute.
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int                cur_col    = 0;
  int                cur_row    = 0;
  logic [ATTR_W-1:0] attr_model = ATTR_RESET;

  // Applies one accepted command to the shadow console and returns the
  // cursor report that the console must produce for it.
  function automatic out_item_t emulate_console(in_item_t cmd);
    out_item_t         rep;
    logic [CELL_W-1:0] read_word;
    read_word = '0;
    case (cmd.operation)
      OP_PUT: begin
        if (cmd.character == CH_BS) begin
          if (cur_col > 0) cur_col--;
        end else if (cmd.character == CH_TAB) begin
          cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
        end else if (cmd.character == CH_CR) begin
          cur_col = 0;
        end else if (cmd.character == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (cmd.character >= CH_PRINT_LO && cmd.character <= CH_PRINT_HI) begin
          screen_model[cur_row * COLUMNS + cur_col] = {attr_model, cmd.character};
          cur_col++;
        end
        // Running off the right edge continues on the next row.
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // Running off the bottom moves every row up and blanks the last one.
        if (cur_row >= ROWS) begin
          for (int i = 0; i < SCROLL_LEN; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (int i = SCROLL_LEN; i < CELL_COUNT; i++) screen_model[i] = {attr_model, CH_BLANK};
          cur_row = ROWS - 1;
          scroll_count++;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {attr_model, CH_BLANK};
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      OP_READ: begin
        // Addresses past the last cell read as zero.
        if (cmd.cell_index < CELL_COUNT) read_word = screen_model[cmd.cell_index];
        read_count++;
      end
      default: ;
    endcase
    rep.cursor_location = LOC_W'(cur_row * COLUMNS + cur_col);
    rep.cursor_column   = COL_W'(cur_col);
    rep.cursor_row      = ROW_W'(cur_row);
    rep.cell_value      = read_word;
    return rep;
  endfunction

  function automatic int draw_gap();
    return brisk ? 0 : $urandom_range(MAX_GAP, 0);
  endfunction

  task automatic check_field(string label, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Adds one command to the backlog and grows the cycle estimate. A newline or
  // a clear may cost a full screen sweep; printable bytes and tabs only reach
  // a scroll after a whole row of them.
  task automatic queue_cmd(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic [LOC_W-1:0] idx);
    in_item_t cmd;
    bit       is_ctrl;
    bit       is_print;
    cmd.operation  = op;
    cmd.character  = ch;
    cmd.cell_index = idx;
    cmd_backlog.push_back(cmd);
    queued_cmds++;
    is_ctrl  = (ch == CH_BS || ch == CH_TAB || ch == CH_CR || ch == CH_LF);
    is_print = (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI);
    budget += 2 * (MAX_GAP + 1) + 8;
    if (op == OP_CLEAR || (op == OP_PUT && ch == CH_LF)) budget += CELL_COUNT + 100;
    else if (op == OP_PUT && ch == CH_TAB) budget += (CELL_COUNT + 100) / 10;
    else if (op == OP_PUT && is_print) budget += (CELL_COUNT + 100) / COLUMNS;
    if (op == OP_CLEAR || op == OP_READ || (op == OP_PUT && (is_ctrl || is_print)))
      counted_cmds++;
  endtask

  // One stretch of random traffic. Most of it looks like software writing
  // lines of text and reading cells back; the rest is newline runs that
  // push the cursor to the bottom, bursts of reads, noise and the odd clear.
  task automatic queue_random_sequence();
    int pick;
    int len;
    int r;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 60) : $urandom_range(40, 0);
      repeat (len) begin
        r = $urandom_range(99, 0);
        if (r < 82) queue_cmd(OP_PUT, CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)),
                              LOC_W'($urandom));
        else if (r < 88) queue_cmd(OP_PUT, CH_TAB, LOC_W'($urandom));
        else if (r < 94) queue_cmd(OP_PUT, CH_BS, LOC_W'($urandom));
        else if (r < 97) queue_cmd(OP_PUT, CH_CR, LOC_W'($urandom));
        else queue_cmd(OP_READ, CHAR_W'($urandom), LOC_W'($urandom_range(CELL_COUNT - 1, 0)));
      end
      if ($urandom_range(1, 0) == 1) queue_cmd(OP_PUT, CH_CR, LOC_W'($urandom));
      queue_cmd(OP_PUT, CH_LF, LOC_W'($urandom));
      repeat ($urandom_range(3, 0))
        queue_cmd(OP_READ, CHAR_W'($urandom), LOC_W'($urandom_range(CELL_COUNT - 1, 0)));
    end else if (pick < 63) begin
      repeat ($urandom_range(30, 1)) queue_cmd(OP_PUT, CH_LF, LOC_W'($urandom));
    end else if (pick < 80) begin
      repeat ($urandom_range(8, 1)) begin
        r = $urandom_range(99, 0);
        if (r < 70) len = $urandom_range(CELL_COUNT - 1, 0);
        else if (r < 90) len = $urandom_range(CELL_COUNT - 1, SCROLL_LEN);
        else len = $urandom_range(MAX_INDEX, CELL_COUNT);
        queue_cmd(OP_READ, CHAR_W'($urandom), LOC_W'(len));
      end
    end else if (pick < 96) begin
      repeat ($urandom_range(6, 1)) begin
        r = $urandom_range(2, 0);
        queue_cmd(r == 0 ? OP_PUT : (r == 1 ? OP_READ : OP_SPARE),
                  CHAR_W'($urandom), LOC_W'($urandom));
      end
    end else begin
      queue_cmd(OP_CLEAR, CHAR_W'($urandom), LOC_W'($urandom));
    end
  endtask

  // Waits until every queued command has been taken and every report checked.
  task automatic wait_until_idle();
    while (accepted_cmds != queued_cmds || due_reports.size() != 0) @(negedge clk);
  endtask

  // Sender: presents the backlog in order, pausing a random number of cycles
  // after each accepted transaction. Push stays high when the next command
  // follows without a gap.
  always @(negedge clk) begin : send_cmds
    logic offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      offer = push && !in_fire;
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() != 0) begin
          item <= cmd_backlog.pop_front();
          offer = 1'b1;
          send_gap = draw_gap();
        end
      end
      push <= offer;
    end
  end

  // Receiver: after each accepted result it waits a random number of cycles
  // before it asks for the next one, and it refuses everything while held off.
  always @(negedge clk) begin : take_results
    logic ready;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      ready = pop && !out_fire && !hold_results;
      if (pop && out_fire) recv_gap = draw_gap();
      if (!ready && !hold_results) begin
        if (recv_gap > 0) recv_gap--;
        else ready = 1'b1;
      end
      pop <= ready;
    end
  end

  // Monitor: at each rising edge it records attribute writes, predicts each
  // accepted command and checks each accepted result against the oldest
  // outstanding report.
  always @(posedge clk) begin : observe
    out_item_t want;
    if (rst) begin
      in_fire  = 1'b0;
      out_fire = 1'b0;
    end else begin
      in_fire  = push && !full;
      out_fire = pop && !empty;
      if (cfg_we) attr_model = cfg_data;
      if (in_fire) begin
        due_reports.push_back(emulate_console(item));
        accepted_cmds++;
      end
      if (out_fire) begin
        if (due_reports.size() == 0) begin
          $display("%0t: result transaction with no report outstanding, actual %p",
                   $time, result);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          check_field("cursor_location", want.cursor_location, result.cursor_location);
          check_field("cursor_column", want.cursor_column, result.cursor_column);
          check_field("cursor_row", want.cursor_row, result.cursor_row);
          check_field("cell_value", want.cell_value, result.cell_value);
          checked_results++;
        end
      end
    end
  end

  // Long receiver stall once traffic is flowing: the result queue and the
  // command queue fill up and full must rise while the sender keeps offering.
  initial begin : back_pressure
    while (accepted_cmds < HOLD_AFTER) @(negedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_results <= 1'b0;
  end

  // Watchdog. The limit follows the queued work, so it grows with the run.
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > 3 * budget + 20000 + HOLD_CYCLES) begin
      $display("%0t: run stalled after %0d cycles with %0d reports outstanding",
               $time, cycles, due_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ATTR_W-1:0] shade_plan [PHASES];
    int                goal;
    shade_plan = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h01, 8'h7F};
    shade_plan[2] = ATTR_W'($urandom);
    shade_plan[4] = ATTR_W'($urandom);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening at the reset attribute. The screen holds nothing
    // defined until the first clear, so the clear goes first.
    queue_cmd(OP_CLEAR, 8'hFF, LOC_W'(MAX_INDEX));
    queue_cmd(OP_PUT, CH_BS, '0);                 // backspace at column 0 does nothing
    queue_cmd(OP_PUT, 8'h41, '0);
    queue_cmd(OP_PUT, CH_PRINT_LO, '0);           // lowest printable byte
    queue_cmd(OP_PUT, CH_PRINT_HI, '0);           // highest printable byte
    queue_cmd(OP_READ, '0, LOC_W'(0));
    queue_cmd(OP_READ, '0, LOC_W'(2));
    queue_cmd(OP_READ, 8'hFF, LOC_W'(CELL_COUNT - 1));
    queue_cmd(OP_READ, '0, LOC_W'(CELL_COUNT));   // first address past the screen
    queue_cmd(OP_READ, '0, LOC_W'(MAX_INDEX));
    queue_cmd(OP_PUT, CH_BS, '0);
    queue_cmd(OP_PUT, CH_TAB, '0);
    queue_cmd(OP_PUT, CH_TAB, '0);
    queue_cmd(OP_PUT, CH_CR, '0);
    queue_cmd(OP_PUT, CH_LF, '0);
    queue_cmd(OP_PUT, 8'h00, '0);                 // bytes below and above the
    queue_cmd(OP_PUT, 8'h1F, '0);                 // printable range are ignored
    queue_cmd(OP_PUT, 8'h80, '0);
    queue_cmd(OP_PUT, 8'hFF, LOC_W'(MAX_INDEX));
    queue_cmd(OP_SPARE, 8'hFF, LOC_W'(MAX_INDEX));
    queue_cmd(OP_PUT, 8'h7E, '0);
    queue_cmd(OP_READ, '0, LOC_W'(COLUMNS));

    // Random phases, each under its own attribute. The attribute only
    // changes once the console has answered everything sent before.
    for (int p = 0; p < PHASES; p++) begin
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_data <= shade_plan[p];
      @(negedge clk);
      cfg_we <= 1'b0;
      shades_used++;
      budget += SETTLE_CYCLES + 10;
      brisk = (p == 2 || p == 5);
      goal  = counted_cmds + ITEMS_WANTED / PHASES;
      while (counted_cmds < goal) queue_random_sequence();
    end

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, due_reports.size());
      mismatches++;
    end

    $display("Checked %0d result transactions under %0d attribute settings.",
             checked_results, shades_used);
    $display("Covered %0d clears, %0d scrolls and %0d cell reads; %0d mismatches.",
             clear_count, scroll_count, read_count, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
